[design/thb_pkg.sv]
// Shared types, constants and checksum helpers for the TCP/IPv4 header builder.
// No dependencies; imported by every module of the block.
package thb_pkg;

    // Widths of the input beat data and of the output user field
    localparam int unsigned IN_DATA_W  = 120;
    localparam int unsigned OUT_USER_W = 5;

    localparam logic [15:0] MAX_PAYLOAD    = 16'd65495;
    localparam logic [15:0] IP_HDR_BYTES   = 16'd40;
    localparam logic [15:0] TCP_HDR_BYTES  = 16'd20;
    localparam logic [15:0] IP_VER_IHL_TOS = 16'h4500;
    localparam logic [7:0]  IP_TTL         = 8'd64;
    localparam logic [7:0]  IP_PROTO_TCP   = 8'd6;
    localparam logic [15:0] TCP_OFF_FLAGS  = 16'h5018;
    localparam logic [15:0] TCP_WINDOW     = 16'hFFFF;

    // Constant parts of the two checksums
    localparam logic [19:0] IP_CONST_SUM  = 20'({IP_TTL, IP_PROTO_TCP}) + 20'(IP_VER_IHL_TOS);
    localparam logic [19:0] TCP_CONST_SUM = 20'(IP_PROTO_TCP) + 20'(TCP_OFF_FLAGS)
                                          + 20'(TCP_WINDOW);

    typedef enum logic [3:0] {
        W_IP_LEN    = 4'd0,
        W_IP_IDENT  = 4'd1,
        W_IP_TTL    = 4'd2,
        W_IP_SRC    = 4'd3,
        W_IP_DST    = 4'd4,
        W_TCP_PORTS = 4'd5,
        W_TCP_SEQ   = 4'd6,
        W_TCP_ACK   = 4'd7,
        W_TCP_FLAGS = 4'd8,
        W_TCP_CSUM  = 4'd9
    } word_idx_t;

    // Finished packet leaving the accumulator
    typedef struct packed {
        logic [15:0] psum;
        logic [15:0] count;
        logic        ovf;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [15:0] ident;
    } pkt_t;

    // Per-packet fields the word sequencer needs for one header
    typedef struct packed {
        logic [15:0] total_len;
        logic [15:0] ident;
        logic [15:0] ip_csum;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [15:0] tcp_csum;
        logic        ovf;
    } frame_t;

    // Ones-complement add with end-around carry
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // Fold a wide sum down to 16 bits, keeping ones-complement value
    function automatic logic [15:0] fold20(input logic [19:0] x);
        logic [16:0] a;
        logic [15:0] b;
        a = {1'b0, x[15:0]} + {13'd0, x[19:16]};
        b = a[15:0] + {15'd0, a[16]};
        return b;
    endfunction

endpackage

[design/tcp_ipv4_header_builder.sv]
// The first header word appears once the closing beat has passed the input, packet,
// checksum and frame registers. One payload byte per cycle while s_tready is high;
// each packet then sends ten words, one per cycle while m_tready is high. Up to three
// finished packets wait; the checksum stage and word sequencer read the addresses.
// Reset (rst_n low, asynchronous) clears the sums, counts, valids and addresses.
// Depends on thb_pkg, thb_accum, thb_csum, thb_emit.
module tcp_ipv4_header_builder
    import thb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // payload stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,  // payload_byte, source_port, destination_port,
                                            // sequence_number, acknowledge_number, ip_ident
    input  logic                  s_tuser,  // byte_valid
    input  logic                  s_tlast,  // end_of_payload
    // header stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,  // header_word
    output logic [OUT_USER_W-1:0] m_tuser,  // word_index, length_overflow
    output logic                  m_tlast,  // last_word
    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam logic REG_SRC = 1'b0;
    localparam logic REG_DST = 1'b1;

    logic [31:0] ip_src_reg;
    logic [31:0] ip_dst_reg;
    logic        cfg_wr;

    logic        pkt_valid;
    logic        pkt_take;
    pkt_t        pkt;
    logic        frm_valid;
    logic        frm_take;
    frame_t      frm;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ip_src_reg <= 32'd0;
            ip_dst_reg <= 32'd0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_SRC: ip_src_reg <= pwdata;
                REG_DST: ip_dst_reg <= pwdata;
                default: ip_src_reg <= ip_src_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_SRC: prdata = ip_src_reg;
            REG_DST: prdata = ip_dst_reg;
            default: prdata = 32'd0;
        endcase
    end

    thb_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .pkt_take  (pkt_take),
        .pkt_valid (pkt_valid),
        .pkt       (pkt)
    );

    thb_csum u_csum (
        .clk       (clk),
        .rst_n     (rst_n),
        .ip_src    (ip_src_reg),
        .ip_dst    (ip_dst_reg),
        .pkt_valid (pkt_valid),
        .pkt       (pkt),
        .pkt_take  (pkt_take),
        .frm_valid (frm_valid),
        .frm       (frm),
        .frm_take  (frm_take)
    );

    thb_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .ip_src    (ip_src_reg),
        .ip_dst    (ip_dst_reg),
        .frm_valid (frm_valid),
        .frm       (frm),
        .frm_take  (frm_take),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

[design/thb_accum.sv]
// Input register and payload accumulator: running ones-complement sum, byte count.
// Depends on thb_pkg; hands one pkt_t per packet to the checksum pipeline.
module thb_accum
    import thb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 s_tlast,
    input  logic                 pkt_take,
    output logic                 pkt_valid,
    output pkt_t                 pkt
);

    logic                 in_v_reg;
    logic [IN_DATA_W-1:0] in_data_reg;
    logic                 in_user_reg;
    logic                 in_last_reg;

    logic [15:0] sum_reg;
    logic [15:0] count_reg;
    logic        odd_reg;
    logic [7:0]  held_reg;
    logic        ovf_reg;

    logic        pkt_v_reg;
    pkt_t        pkt_reg;

    logic        in_adv;
    logic        s_accept;
    logic        room;
    logic        byte_take;
    logic        pair_add;
    logic        odd_after;
    logic [7:0]  held_after;
    logic [15:0] count_after;
    logic        ovf_after;
    logic [15:0] addend;
    logic [15:0] sum_after;
    logic [7:0]  in_byte;

    assign in_adv   = in_v_reg && (!in_last_reg || !pkt_v_reg || pkt_take);
    assign s_tready = !in_v_reg || in_adv;
    assign s_accept = s_tvalid && s_tready;

    assign in_byte     = in_data_reg[7:0];
    assign room        = count_reg < MAX_PAYLOAD;
    assign byte_take   = in_user_reg && room;
    assign pair_add    = byte_take && odd_reg;
    assign odd_after   = byte_take ? !odd_reg : odd_reg;
    assign held_after  = pair_add ? 8'd0 : (byte_take ? in_byte : held_reg);
    assign count_after = count_reg + {15'd0, byte_take};
    assign ovf_after   = ovf_reg || (in_user_reg && !room);

    // Add each completed byte pair; pad an odd trailing byte with zero on the closing beat
    always_comb
    begin
        if (pair_add)
            addend = {held_reg, in_byte};
        else if (in_last_reg && odd_after)
            addend = {held_after, 8'd0};
        else
            addend = 16'd0;
    end

    assign sum_after = ones_add(sum_reg, addend);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            sum_reg   <= 16'd0;
            count_reg <= 16'd0;
            odd_reg   <= 1'b0;
            held_reg  <= 8'd0;
            ovf_reg   <= 1'b0;
            pkt_v_reg <= 1'b0;
        end
        else
        begin
            if (s_accept)
                in_v_reg <= 1'b1;
            else if (in_adv)
                in_v_reg <= 1'b0;

            if (in_adv)
            begin
                if (in_last_reg)
                begin
                    sum_reg   <= 16'd0;
                    count_reg <= 16'd0;
                    odd_reg   <= 1'b0;
                    held_reg  <= 8'd0;
                    ovf_reg   <= 1'b0;
                end
                else
                begin
                    sum_reg   <= sum_after;
                    count_reg <= count_after;
                    odd_reg   <= odd_after;
                    held_reg  <= held_after;
                    ovf_reg   <= ovf_after;
                end
            end

            if (in_adv && in_last_reg)
                pkt_v_reg <= 1'b1;
            else if (pkt_take)
                pkt_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_data_reg <= s_tdata;
            in_user_reg <= s_tuser;
            in_last_reg <= s_tlast;
        end
        if (in_adv && in_last_reg)
        begin
            pkt_reg.psum  <= sum_after;
            pkt_reg.count <= count_after;
            pkt_reg.ovf   <= ovf_after;
            pkt_reg.sport <= in_data_reg[23:8];
            pkt_reg.dport <= in_data_reg[39:24];
            pkt_reg.seq   <= in_data_reg[71:40];
            pkt_reg.ack   <= in_data_reg[103:72];
            pkt_reg.ident <= in_data_reg[119:104];
        end
    end

    assign pkt_valid = pkt_v_reg;
    assign pkt       = pkt_reg;

endmodule

[design/thb_csum.sv]
// Two-stage checksum pipeline: partial sums, then IPv4 and TCP totals and fold.
// Depends on thb_pkg; takes pkt_t from thb_accum, gives frame_t to thb_emit.
module thb_csum
    import thb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] ip_src,
    input  logic [31:0] ip_dst,
    input  logic        pkt_valid,
    input  pkt_t        pkt,
    output logic        pkt_take,
    output logic        frm_valid,
    output frame_t      frm,
    input  logic        frm_take
);

    logic        s1_v_reg;
    pkt_t        s1_pkt_reg;
    logic [17:0] s1_addr_reg;
    logic [18:0] s1_hdr_reg;

    logic        s2_v_reg;
    pkt_t        s2_pkt_reg;
    logic [19:0] s2_ip_reg;
    logic [19:0] s2_tcp_reg;

    logic        s2_take;
    logic        s1_take;
    logic        s1_load;
    logic        s2_load;
    logic [15:0] s1_total_len;
    logic [15:0] s1_tcp_len;

    assign s2_take  = !s2_v_reg || frm_take;
    assign s1_take  = !s1_v_reg || s2_take;
    assign pkt_take = s1_take;
    assign s1_load  = pkt_valid && s1_take;
    assign s2_load  = s1_v_reg && s2_take;

    assign s1_total_len = s1_pkt_reg.count + IP_HDR_BYTES;
    assign s1_tcp_len   = s1_pkt_reg.count + TCP_HDR_BYTES;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            if (s1_take)
                s1_v_reg <= pkt_valid;
            if (s2_take)
                s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_pkt_reg  <= pkt;
            s1_addr_reg <= 18'(ip_src[31:16]) + 18'(ip_src[15:0])
                         + 18'(ip_dst[31:16]) + 18'(ip_dst[15:0]);
            s1_hdr_reg  <= 19'(pkt.sport) + 19'(pkt.dport)
                         + 19'(pkt.seq[31:16]) + 19'(pkt.seq[15:0])
                         + 19'(pkt.ack[31:16]) + 19'(pkt.ack[15:0]);
        end
        if (s2_load)
        begin
            s2_pkt_reg <= s1_pkt_reg;
            s2_ip_reg  <= 20'(s1_addr_reg) + 20'(s1_pkt_reg.ident)
                        + 20'(s1_total_len) + IP_CONST_SUM;
            s2_tcp_reg <= 20'(s1_addr_reg) + 20'(s1_hdr_reg) + 20'(s1_pkt_reg.psum)
                        + 20'(s1_tcp_len) + TCP_CONST_SUM;
        end
    end

    always_comb
    begin
        frm.total_len = s2_pkt_reg.count + IP_HDR_BYTES;
        frm.ident     = s2_pkt_reg.ident;
        frm.ip_csum   = ~fold20(s2_ip_reg);
        frm.sport     = s2_pkt_reg.sport;
        frm.dport     = s2_pkt_reg.dport;
        frm.seq       = s2_pkt_reg.seq;
        frm.ack       = s2_pkt_reg.ack;
        frm.tcp_csum  = ~fold20(s2_tcp_reg);
        frm.ovf       = s2_pkt_reg.ovf;
    end

    assign frm_valid = s2_v_reg;

endmodule

[design/thb_emit.sv]
// Header word sequencer: holds one frame and sends its ten words, one per beat.
// Depends on thb_pkg; takes frame_t from thb_csum.
module thb_emit
    import thb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [31:0]           ip_src,
    input  logic [31:0]           ip_dst,
    input  logic                  frm_valid,
    input  frame_t                frm,
    output logic                  frm_take,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // header_word
    output logic [OUT_USER_W-1:0] m_tuser,   // [3:0] word_index, [4] length_overflow
    output logic                  m_tlast
);

    logic      busy_reg;
    word_idx_t idx_reg;
    frame_t    frame_reg;

    logic      beat;
    logic      last_beat;
    logic      load;

    assign beat      = busy_reg && m_tready;
    assign last_beat = beat && (idx_reg == W_TCP_CSUM);
    assign frm_take  = !busy_reg || last_beat;
    assign load      = frm_valid && frm_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= W_IP_LEN;
        end
        else
        begin
            if (load)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= W_IP_LEN;
            end
            else if (beat)
            begin
                busy_reg <= !last_beat;
                idx_reg  <= word_idx_t'(idx_reg + 4'd1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            frame_reg <= frm;
    end

    always_comb
    begin
        unique case (idx_reg)
            W_IP_LEN:    m_tdata = {IP_VER_IHL_TOS, frame_reg.total_len};
            W_IP_IDENT:  m_tdata = {frame_reg.ident, 16'd0};
            W_IP_TTL:    m_tdata = {IP_TTL, IP_PROTO_TCP, frame_reg.ip_csum};
            W_IP_SRC:    m_tdata = ip_src;
            W_IP_DST:    m_tdata = ip_dst;
            W_TCP_PORTS: m_tdata = {frame_reg.sport, frame_reg.dport};
            W_TCP_SEQ:   m_tdata = frame_reg.seq;
            W_TCP_ACK:   m_tdata = frame_reg.ack;
            W_TCP_FLAGS: m_tdata = {TCP_OFF_FLAGS, TCP_WINDOW};
            W_TCP_CSUM:  m_tdata = {frame_reg.tcp_csum, 16'd0};
            default:     m_tdata = 32'd0;
        endcase
    end

    assign m_tvalid = busy_reg;
    assign m_tuser  = {frame_reg.ovf, idx_reg};
    assign m_tlast  = (idx_reg == W_TCP_CSUM);

endmodule

[design/thb_checker.sv]
// Port-level checks on the header stream of tcp_ipv4_header_builder.
// Depends on thb_pkg; attached to the top level by the bind below.
module thb_checker
    import thb_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [31:0]           m_tdata,
    input logic [OUT_USER_W-1:0] m_tuser,
    input logic                  m_tlast
);

    // tlast marks exactly the checksum word
    a_last_on_final_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser[3:0] == W_TCP_CSUM)))
        else $error("tlast does not match the final word index");

    // words of one header follow back to back in order
    a_index_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=>
            (m_tvalid && (m_tuser[3:0] == $past(m_tuser[3:0]) + 4'd1)))
        else $error("header word index did not advance by one");

    // overflow flag is the same on every word of a header
    a_ovf_steady: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tuser[4] == $past(m_tuser[4])))
        else $error("length_overflow changed inside one header");

    // first word carries version, IHL and TOS
    a_first_word: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser[3:0] == W_IP_LEN)) |-> (m_tdata[31:16] == IP_VER_IHL_TOS))
        else $error("first header word has a bad version field");

    // a stalled beat holds its data
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("header beat changed while stalled");

endmodule

bind tcp_ipv4_header_builder thb_checker u_thb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

[bench/testbench.sv]
// Self-checking bench for the TCP/IPv4 header builder: streams payload beats with
// random bursts and gaps, predicts the ten header words of each packet and checks them.
// Depends on thb_pkg and tcp_ipv4_header_builder.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import thb_pkg::*;

    localparam logic [2:0] REG_SRC_ADDR   = 3'd0;
    localparam logic [2:0] REG_DST_ADDR   = 3'd4;
    localparam int         DRAIN_CYCLES   = 12;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         PHASE_ITEMS    = 55;

    typedef struct packed {
        logic [7:0]  pbyte;
        logic        bvalid;
        logic        eop;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [15:0] ident;
    } payload_item_t;

    typedef struct {
        logic [31:0] word;
        word_idx_t   idx;
        logic        last;
        logic        ovf;
    } header_beat_t;

    // optional hand-typed first header word for a closing beat
    typedef struct {
        logic        on;
        logic [31:0] word;
    } len_pin_t;

    typedef struct {
        payload_item_t item;
        len_pin_t      pin;
    } dir_row_t;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_STALLS
    } rx_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [31:0]           m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  m_tlast;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [2:0]            paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    // predictor state
    logic [15:0]  sum_acc;
    logic [15:0]  byte_cnt;
    logic         odd_hold;
    logic [7:0]   high_byte;
    logic         ovf_hold;
    logic [31:0]  cfg_src;
    logic [31:0]  cfg_dst;

    header_beat_t header_expect_q[$];
    len_pin_t     len_pin_q[$];
    dir_row_t     dir_tab[$];
    int           mismatches = 0;
    int           idle_cycles = 0;
    int           burst_left = 0;
    int           gap_max = 0;
    int           burst_max = 1;
    rx_mode_t     rx_mode = RX_OPEN;
    int           rx_mode_left = 0;
    int           rx_stall_left = 0;

    tcp_ipv4_header_builder uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] oc_fold(input logic [31:0] s);
        s = (s & 32'h0000FFFF) + (s >> 16);
        s = (s & 32'h0000FFFF) + (s >> 16);
        return s[15:0];
    endfunction

    function automatic logic [15:0] oc_add16(input logic [15:0] s, input logic [15:0] w);
        return oc_fold({16'd0, s} + {16'd0, w});
    endfunction

    function automatic logic [15:0] oc_add32(input logic [15:0] s, input logic [31:0] v);
        return oc_add16(oc_add16(s, v[31:16]), v[15:0]);
    endfunction

    task automatic clear_packet_state();
        sum_acc   = '0;
        byte_cnt  = '0;
        odd_hold  = 1'b0;
        high_byte = '0;
        ovf_hold  = 1'b0;
    endtask

    // Fold one accepted beat into the packet sums; on the closing beat queue ten words.
    task automatic predict_header(input payload_item_t it);
        logic [31:0]  w [0:9];
        logic [15:0]  psum;
        logic [15:0]  ip_sum;
        logic [15:0]  tcp_sum;
        logic [15:0]  tcp_len;
        logic [15:0]  tot_len;
        len_pin_t     pin;
        header_beat_t hb;
        int           k;
        if (it.bvalid)
        begin
            if (byte_cnt >= MAX_PAYLOAD)
                ovf_hold = 1'b1;
            else
            begin
                byte_cnt = byte_cnt + 16'd1;
                if (odd_hold)
                begin
                    sum_acc   = oc_add16(sum_acc, {high_byte, it.pbyte});
                    odd_hold  = 1'b0;
                    high_byte = '0;
                end
                else
                begin
                    high_byte = it.pbyte;
                    odd_hold  = 1'b1;
                end
            end
        end
        if (it.eop)
        begin
            psum = sum_acc;
            if (odd_hold)
                psum = oc_add16(psum, {high_byte, 8'h00});
            tcp_len = TCP_HDR_BYTES + byte_cnt;
            tot_len = IP_HDR_BYTES + byte_cnt;

            w[0] = {IP_VER_IHL_TOS, tot_len};
            w[1] = {it.ident, 16'h0000};
            w[2] = {IP_TTL, IP_PROTO_TCP, 16'h0000};
            w[3] = cfg_src;
            w[4] = cfg_dst;
            ip_sum = '0;
            for (k = 0; k < 5; k++)
                ip_sum = oc_add32(ip_sum, w[k]);
            w[2][15:0] = ~ip_sum;

            w[5] = {it.sport, it.dport};
            w[6] = it.seq;
            w[7] = it.ack;
            w[8] = {TCP_OFF_FLAGS, TCP_WINDOW};
            w[9] = '0;
            tcp_sum = oc_add32(psum, cfg_src);
            tcp_sum = oc_add32(tcp_sum, cfg_dst);
            tcp_sum = oc_add16(tcp_sum, {8'd0, IP_PROTO_TCP});
            tcp_sum = oc_add16(tcp_sum, tcp_len);
            for (k = 5; k < 10; k++)
                tcp_sum = oc_add32(tcp_sum, w[k]);
            w[9] = {~tcp_sum, 16'h0000};

            if (len_pin_q.size() != 0)
            begin
                pin = len_pin_q.pop_front();
                if (pin.on)
                    w[0] = pin.word;
            end
            for (k = 0; k < 10; k++)
            begin
                hb.word = w[k];
                hb.idx  = word_idx_t'(k);
                hb.last = (hb.idx == W_TCP_CSUM);
                hb.ovf  = ovf_hold;
                header_expect_q.push_back(hb);
            end
            clear_packet_state();
        end
    endtask

    // Predict on accepted payload beats, check accepted header beats.
    always @(posedge clk)
    begin : monitor
        payload_item_t seen;
        header_beat_t  want;
        if (rst_n && s_tvalid && s_tready)
        begin
            seen.pbyte  = s_tdata[7:0];
            seen.sport  = s_tdata[23:8];
            seen.dport  = s_tdata[39:24];
            seen.seq    = s_tdata[71:40];
            seen.ack    = s_tdata[103:72];
            seen.ident  = s_tdata[119:104];
            seen.bvalid = s_tuser;
            seen.eop    = s_tlast;
            predict_header(seen);
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (header_expect_q.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected header beat: word %h idx %0d last %b ovf %b",
                             m_tdata, m_tuser[3:0], m_tlast, m_tuser[4]);
                mismatches++;
            end
            else
            begin
                want = header_expect_q.pop_front();
                if (m_tdata !== want.word || m_tuser[3:0] !== want.idx
                    || m_tlast !== want.last || m_tuser[4] !== want.ovf)
                begin
                    if (mismatches < 10)
                        $display("beat %0d: exp %h last %b ovf %b, got %h idx %0d last %b ovf %b",
                                 want.idx, want.word, want.last, want.ovf,
                                 m_tdata, m_tuser[3:0], m_tlast, m_tuser[4]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver backpressure: switch between open, coin-flip and stall stretches.
    always @(posedge clk)
    begin : rx_pattern
        if (rx_mode_left == 0)
        begin
            rx_mode      = rx_mode_t'($urandom_range(0, 2));
            rx_mode_left = $urandom_range(16, 96);
        end
        rx_mode_left--;
        case (rx_mode)
            RX_OPEN:
                m_tready <= 1'b1;
            RX_COIN:
                m_tready <= 1'($urandom_range(0, 1));
            default:
            begin
                if (rx_stall_left > 0)
                begin
                    rx_stall_left--;
                    m_tready <= 1'b0;
                end
                else
                begin
                    m_tready <= 1'b1;
                    if ($urandom_range(0, 3) == 0)
                        rx_stall_left = $urandom_range(1, 12);
                end
            end
        endcase
    end

    task automatic push_payload_beat(input payload_item_t it, input len_pin_t pin);
        int gap;
        if (burst_left == 0)
        begin
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, burst_max);
        end
        if (it.eop)
            len_pin_q.push_back(pin);
        s_tvalid <= 1'b1;
        s_tdata  <= {it.ident, it.ack, it.seq, it.dport, it.sport, it.pbyte};
        s_tuser  <= it.bvalid;
        s_tlast  <= it.eop;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        burst_left--;
    endtask

    function automatic payload_item_t rand_item(input logic bv, input logic eop);
        payload_item_t it;
        it.pbyte  = 8'($urandom_range(0, 255));
        it.bvalid = bv;
        it.eop    = eop;
        it.sport  = 16'($urandom_range(0, 65535));
        it.dport  = 16'($urandom_range(0, 65535));
        it.seq    = $urandom;
        it.ack    = $urandom;
        it.ident  = 16'($urandom_range(0, 65535));
        return it;
    endfunction

    // Drop valid, wait for every header word, then let the pipeline drain.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (header_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (addr == REG_SRC_ADDR)
            cfg_src = value;
        else if (addr == REG_DST_ADDR)
            cfg_dst = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        // paddr still points at the register just written
        if (prdata !== value)
        begin
            if (mismatches < 10)
                $display("register %0d readback: expected %h, got %h", addr, value, prdata);
            mismatches++;
        end
    endtask

    task automatic add_row(input logic [7:0] pb, input logic bv, input logic eop,
                           input logic [15:0] sp, input logic [15:0] dp,
                           input logic [31:0] sq, input logic [31:0] ak,
                           input logic [15:0] idn, input logic pin_on,
                           input logic [31:0] pin_word);
        dir_row_t r;
        r.item     = '{pb, bv, eop, sp, dp, sq, ak, idn};
        r.pin.on   = pin_on;
        r.pin.word = pin_word;
        dir_tab.push_back(r);
    endtask

    // Random packets: mostly short, some empty, a few longer, with ignored beats mixed in.
    task automatic run_random_traffic(input int budget);
        int            sent;
        int            len;
        int            k;
        logic          close_on_byte;
        payload_item_t it;
        len_pin_t      nopin;
        nopin.on   = 1'b0;
        nopin.word = '0;
        sent = 0;
        while (sent < budget)
        begin
            case ($urandom_range(0, 9))
                0:       len = 0;
                9:       len = $urandom_range(17, 64);
                default: len = $urandom_range(1, 16);
            endcase
            close_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
            for (k = 0; k < len; k++)
            begin
                if ($urandom_range(0, 7) == 0)
                    push_payload_beat(rand_item(1'b0, 1'b0), nopin);
                it = rand_item(1'b1, close_on_byte && (k == len - 1));
                push_payload_beat(it, nopin);
                sent++;
            end
            if (!close_on_byte)
            begin
                push_payload_beat(rand_item(1'b0, 1'b1), nopin);
                sent++;
            end
        end
    endtask

    initial
    begin : stimulus
        int          i;
        int          ph;
        logic [31:0] src;
        logic [31:0] dst;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        s_tlast  = 1'b0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        cfg_src  = '0;
        cfg_dst  = '0;
        clear_packet_state();

        // empty packets, all-ones header fields, ignored beats, odd padding, all-ones bytes
        add_row(8'h00, 1'b0, 1'b1, 16'h0000, 16'h0000, 32'h0000_0000, 32'h0000_0000, 16'h0000,
                1'b1, 32'h4500_0028);
        add_row(8'h00, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                1'b1, 32'h4500_0028);
        add_row(8'hA5, 1'b0, 1'b0, 16'h1111, 16'h2222, 32'h3333_3333, 32'h4444_4444, 16'h5555,
                1'b0, 32'h0);
        add_row(8'hFF, 1'b1, 1'b1, 16'h1234, 16'h0050, 32'h0000_0001, 32'h8000_0000, 16'h0001,
                1'b1, 32'h4500_0029);
        add_row(8'h00, 1'b1, 1'b0, 16'h0000, 16'h0000, 32'h0000_0000, 32'h0000_0000, 16'h0000,
                1'b0, 32'h0);
        add_row(8'h00, 1'b1, 1'b1, 16'h0000, 16'h0000, 32'h0000_0000, 32'h0000_0000, 16'h0000,
                1'b1, 32'h4500_002A);
        add_row(8'hFF, 1'b1, 1'b0, 16'h0000, 16'h0000, 32'h0000_0000, 32'h0000_0000, 16'h0000,
                1'b0, 32'h0);
        add_row(8'hFF, 1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                1'b0, 32'h0);
        add_row(8'hFF, 1'b1, 1'b0, 16'h0000, 16'h0000, 32'h0000_0000, 32'h0000_0000, 16'h0000,
                1'b0, 32'h0);
        add_row(8'h00, 1'b0, 1'b1, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 32'h0000_0000, 16'hFFFE,
                1'b1, 32'h4500_002B);
        add_row(8'h12, 1'b1, 1'b0, 16'h0000, 16'h0000, 32'h0000_0000, 32'h0000_0000, 16'h0000,
                1'b0, 32'h0);
        add_row(8'h34, 1'b1, 1'b0, 16'h0000, 16'h0000, 32'h0000_0000, 32'h0000_0000, 16'h0000,
                1'b0, 32'h0);
        add_row(8'h5A, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                1'b0, 32'h0);
        add_row(8'h56, 1'b1, 1'b1, 16'h8000, 16'h0001, 32'h8000_0000, 32'h0000_0001, 16'h7FFF,
                1'b0, 32'h0);
        add_row(8'hFF, 1'b1, 1'b0, 16'h0000, 16'h0000, 32'h0000_0000, 32'h0000_0000, 16'h0000,
                1'b0, 32'h0);
        add_row(8'hFF, 1'b1, 1'b0, 16'h0000, 16'h0000, 32'h0000_0000, 32'h0000_0000, 16'h0000,
                1'b0, 32'h0);
        add_row(8'hFF, 1'b1, 1'b0, 16'h0000, 16'h0000, 32'h0000_0000, 32'h0000_0000, 16'h0000,
                1'b0, 32'h0);
        add_row(8'hFF, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                1'b1, 32'h4500_002C);
        add_row(8'h01, 1'b1, 1'b0, 16'h0000, 16'h0000, 32'h0000_0000, 32'h0000_0000, 16'h0000,
                1'b0, 32'h0);
        add_row(8'h80, 1'b1, 1'b1, 16'h0000, 16'h0000, 32'h0000_0000, 32'h0000_0000, 16'h0000,
                1'b0, 32'h0);
        add_row(8'h00, 1'b0, 1'b1, 16'h0000, 16'h0000, 32'h0000_0000, 32'h0000_0000, 16'h0000,
                1'b1, 32'h4500_0028);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // addresses stay at their reset value for the directed rows
        gap_max   = 2;
        burst_max = 4;
        for (i = 0; i < dir_tab.size(); i++)
            push_payload_beat(dir_tab[i].item, dir_tab[i].pin);
        settle();

        for (ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    src = 32'hFFFF_FFFF;
                    dst = 32'hFFFF_FFFF;
                end
                1:
                begin
                    src = 32'h0000_0000;
                    dst = 32'hFFFF_FFFF;
                end
                2:
                begin
                    src = 32'hFFFF_FFFF;
                    dst = 32'h0000_0000;
                end
                default:
                begin
                    src = $urandom;
                    dst = $urandom;
                end
            endcase
            apb_write(REG_SRC_ADDR, src);
            apb_write(REG_DST_ADDR, dst);
            // first phase runs back to back with no sender gaps
            gap_max   = (ph == 0) ? 0 : $urandom_range(1, 8);
            burst_max = $urandom_range(1, 12);
            run_random_traffic(PHASE_ITEMS);
            settle();
        end

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
